/* rtl/lir_pkg.sv */
// Package for the linear interpolation resampler.
// Holds block sizes, derived widths and step constants, and the beat types.
// No dependencies.
package lir_pkg;

    // Block sizes: IN_PER_BLOCK input positions map onto OUT_PER_BLOCK outputs
    localparam int IN_PER_BLOCK  = 2100;
    localparam int OUT_PER_BLOCK = 2048;

    localparam int SAMPLE_W = 12;
    localparam int RESULT_W = 16;
    localparam int WEIGHT_W = 16;

    // Position runs 0..IN_PER_BLOCK, output index runs 0..OUT_PER_BLOCK
    localparam int POS_W = $clog2(IN_PER_BLOCK + 1);
    localparam int IDX_W = $clog2(OUT_PER_BLOCK + 1);
    localparam int REM_W = (OUT_PER_BLOCK > 1) ? $clog2(OUT_PER_BLOCK) : 1;

    // Per-output step of j*IN/OUT, split into integer and remainder parts
    localparam int STEP_INT = IN_PER_BLOCK / OUT_PER_BLOCK;
    localparam int STEP_REM = IN_PER_BLOCK % OUT_PER_BLOCK;
    // Per-output step of the Q0.16 weight, again as quotient and remainder
    localparam int WSTEP_Q  = (STEP_REM * (2 ** WEIGHT_W)) / OUT_PER_BLOCK;
    localparam int WSTEP_R  = (STEP_REM * (2 ** WEIGHT_W)) % OUT_PER_BLOCK;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(IN_PER_BLOCK);
    localparam logic [IDX_W-1:0] IDX_DONE = IDX_W'(OUT_PER_BLOCK);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(OUT_PER_BLOCK - 1);
    localparam logic [REM_W:0]   REM_MOD  = (REM_W + 1)'(OUT_PER_BLOCK);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_i;
        logic signed [SAMPLE_W-1:0] in_q;
    } in_beat_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] out_i;
        logic signed [RESULT_W-1:0] out_q;
        logic                       block_end;
    } out_beat_t;

    // Scheduler decision for the sample being accepted
    typedef struct packed {
        logic                emit;
        logic                last;
        logic [WEIGHT_W-1:0] weight;
    } sched_t;

endpackage

/* rtl/lir_sched.sv */
// Output scheduler: tracks block position, output index, base and weight.
// Base and weight are stepped incrementally. Depends on lir_pkg.
module lir_sched (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    output lir_pkg::sched_t sched
);
    import lir_pkg::*;

    logic [POS_W-1:0]    pos_reg,  pos_next;
    logic [IDX_W-1:0]    idx_reg,  idx_next;
    logic [POS_W-1:0]    base_reg, base_next;
    logic [REM_W-1:0]    rem_reg,  rem_next;
    logic [WEIGHT_W-1:0] wt_reg,   wt_next;
    logic [REM_W-1:0]    r2_reg,   r2_next;

    logic [REM_W:0]      rem_sum, r2_sum;
    logic                wrap, wcarry, emit;
    logic [REM_W-1:0]    rem_adv, r2_adv;
    logic [POS_W-1:0]    base_adv;
    logic [WEIGHT_W-1:0] wt_adv;

    // base_j advances by IN/OUT with carry from the remainder
    assign rem_sum  = {1'b0, rem_reg} + (REM_W + 1)'(STEP_REM);
    assign wrap     = (rem_sum >= REM_MOD);
    assign rem_adv  = wrap ? REM_W'(rem_sum - REM_MOD) : REM_W'(rem_sum);
    assign base_adv = base_reg + POS_W'(STEP_INT) + POS_W'(wrap);

    // weight = floor(rem * 65536 / OUT), kept as quotient and remainder;
    // the wrap of rem drops exactly 65536, absorbed by the 16-bit wrap
    assign r2_sum   = {1'b0, r2_reg} + (REM_W + 1)'(WSTEP_R);
    assign wcarry   = (r2_sum >= REM_MOD);
    assign r2_adv   = wcarry ? REM_W'(r2_sum - REM_MOD) : REM_W'(r2_sum);
    assign wt_adv   = wt_reg + WEIGHT_W'(WSTEP_Q) + WEIGHT_W'(wcarry);

    assign emit = (pos_reg != '0) && (idx_reg < IDX_DONE) && (base_reg < pos_reg);

    assign sched.emit   = emit;
    assign sched.last   = (idx_reg == IDX_LAST);
    assign sched.weight = wt_reg;

    always_comb
    begin
        pos_next  = pos_reg;
        idx_next  = idx_reg;
        base_next = base_reg;
        rem_next  = rem_reg;
        wt_next   = wt_reg;
        r2_next   = r2_reg;
        if (accept)
        begin
            if (pos_reg >= POS_LAST)
            begin
                // block boundary: last sample becomes index 0 of next block
                pos_next  = POS_W'(1);
                idx_next  = '0;
                base_next = '0;
                rem_next  = '0;
                wt_next   = '0;
                r2_next   = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                if (emit)
                begin
                    idx_next  = idx_reg + IDX_W'(1);
                    base_next = base_adv;
                    rem_next  = rem_adv;
                    wt_next   = wt_adv;
                    r2_next   = r2_adv;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            idx_reg  <= '0;
            base_reg <= '0;
            rem_reg  <= '0;
            wt_reg   <= '0;
            r2_reg   <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            idx_reg  <= idx_next;
            base_reg <= base_next;
            rem_reg  <= rem_next;
            wt_reg   <= wt_next;
            r2_reg   <= r2_next;
        end
    end

    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg <= POS_LAST) && (idx_reg <= IDX_DONE))
        else $error("lir_sched: position or output index out of range");

    a_remainders: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, rem_reg} < REM_MOD) && ({1'b0, r2_reg} < REM_MOD))
        else $error("lir_sched: step remainder not below block size");

    a_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (pos_reg >= POS_LAST) |=> (pos_reg == POS_W'(1)) && (idx_reg == '0))
        else $error("lir_sched: block boundary did not restart the block");

    a_first_out: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg == '0) |-> (base_reg == '0) && (wt_reg == '0))
        else $error("lir_sched: first output of block lacks zero base or weight");

endmodule

/* rtl/lir_interp.sv */
// One channel of the interpolator: prev + (cur - prev) * w, rounded to Q1.15.
// Combinational; depends on lir_pkg.
module lir_interp (
    input  logic signed [lir_pkg::SAMPLE_W-1:0] prev,
    input  logic signed [lir_pkg::SAMPLE_W-1:0] cur,
    input  logic        [lir_pkg::WEIGHT_W-1:0] weight,
    output logic signed [lir_pkg::RESULT_W-1:0] result
);
    import lir_pkg::*;

    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + WEIGHT_W + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam int SHR_W  = ACC_W - (SAMPLE_W);

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc;
    logic signed [SHR_W-1:0]  shifted;

    localparam logic signed [SHR_W-1:0] SAT_HI = SHR_W'((2 ** (RESULT_W - 1)) - 1);
    localparam logic signed [SHR_W-1:0] SAT_LO = -SHR_W'(2 ** (RESULT_W - 1));

    // cur*w + prev*(65536-w) == prev*65536 + (cur-prev)*w
    assign diff = DIFF_W'(cur) - DIFF_W'(prev);
    assign prod = PROD_W'(diff) * $signed({1'b0, weight});
    assign acc  = (ACC_W'(prev) <<< WEIGHT_W) + ACC_W'(prod)
                + ACC_W'(2 ** (WEIGHT_W - (RESULT_W - SAMPLE_W) - 1));
    // round half up at bit 12, then floor shift
    assign shifted = SHR_W'(acc >>> (WEIGHT_W - (RESULT_W - SAMPLE_W)));

    always_comb
    begin
        if (shifted > SAT_HI)
            result = RESULT_W'(SAT_HI);
        else if (shifted < SAT_LO)
            result = RESULT_W'(SAT_LO);
        else
            result = RESULT_W'(shifted);
    end

endmodule

/* rtl/linear_interp_resampler_core.sv */
// Top level of the linear interpolation resampler.
// Instantiates lir_sched and two lir_interp channels; depends on lir_pkg.
//
//  channel | handshake          | payload                  | direction
//  --------+--------------------+--------------------------+----------
//  in      | in_valid/in_ready  | in_data  (in_i, in_q)    | into core
//  out     | out_valid/out_ready| out_data (out_i, out_q,  | out of core
//          |                    |           block_end)     |
//
// One input sample is taken every cycle while in_ready is high. A sample that completes an output
// loads the slot register at its accepting edge, then moves into the output register and
// shows on out_data; the multiply stage between them sets the period.
// Reset clears the block position, output index and the valid flags; the
// first sample after reset is index 0 of the first block and gives no beat.
// A stall on out backs up through the slot register; in_ready falls only
// when both the slot and the output register are full and out_ready is low.
module linear_interp_resampler_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lir_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lir_pkg::out_beat_t out_data
);
    import lir_pkg::*;

    // control
    logic   accept;
    logic   out_free;
    logic   slot_free;
    sched_t sched;

    logic   slot_valid_reg, slot_valid_next;
    logic   out_valid_reg,  out_valid_next;

    // sample history, one sample back
    logic signed [SAMPLE_W-1:0] prev_i_reg, prev_q_reg;

    // slot register: the pair and weight of a pending output beat
    logic signed [SAMPLE_W-1:0] slot_prev_i_reg, slot_prev_q_reg;
    logic signed [SAMPLE_W-1:0] slot_cur_i_reg,  slot_cur_q_reg;
    logic        [WEIGHT_W-1:0] slot_weight_reg;
    logic                       slot_last_reg;

    logic signed [RESULT_W-1:0] res_i, res_q;
    out_beat_t                  out_data_reg;

    assign out_free  = !out_valid_reg || out_ready;
    assign slot_free = !slot_valid_reg || out_free;
    assign in_ready  = slot_free;
    assign accept    = in_valid && in_ready;

    lir_sched u_sched (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sched  (sched)
    );

    lir_interp u_interp_i (
        .prev   (slot_prev_i_reg),
        .cur    (slot_cur_i_reg),
        .weight (slot_weight_reg),
        .result (res_i)
    );

    lir_interp u_interp_q (
        .prev   (slot_prev_q_reg),
        .cur    (slot_cur_q_reg),
        .weight (slot_weight_reg),
        .result (res_q)
    );

    always_comb
    begin
        if (accept && sched.emit)
            slot_valid_next = 1'b1;
        else if (out_free)
            slot_valid_next = 1'b0;
        else
            slot_valid_next = slot_valid_reg;

        out_valid_next = out_free ? slot_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_i_reg     <= '0;
            prev_q_reg     <= '0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            out_valid_reg  <= out_valid_next;
            if (accept)
            begin
                prev_i_reg <= in_data.in_i;
                prev_q_reg <= in_data.in_q;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept && sched.emit)
        begin
            slot_prev_i_reg <= prev_i_reg;
            slot_prev_q_reg <= prev_q_reg;
            slot_cur_i_reg  <= in_data.in_i;
            slot_cur_q_reg  <= in_data.in_q;
            slot_weight_reg <= sched.weight;
            slot_last_reg   <= sched.last;
        end
        if (out_free && slot_valid_reg)
        begin
            out_data_reg.out_i     <= res_i;
            out_data_reg.out_q     <= res_q;
            out_data_reg.block_end <= slot_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
        slot_valid_reg && !out_free |=> slot_valid_reg)
        else $error("core: pending beat lost while output stalled");

    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        slot_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("core: input taken with both stages full");

    a_slot_drain: assert property (@(posedge clk) disable iff (!rst_n)
        slot_valid_reg && out_free |=> out_valid_reg)
        else $error("core: slot drained without output beat");

endmodule
